[design/fcba_pkg.sv]
// Package with shared types and constants for the channel bin averager.
`default_nettype none
package fcba_pkg;
	localparam int DATA_W = 24;
	localparam int WT_W = 16;
	localparam int SUM_W = 56;
	localparam int WSUM_W = 28;
	localparam int RES_W = 40;
	localparam int WIDTH_W = 13;
	localparam int MODE_W = 3;
	// Largest bin; the sum and weight widths above are sized for it.
	localparam int MAX_BIN = 4096;
	localparam logic [WT_W-1:0] ONE_Q8 = 16'd256;

	localparam logic [MODE_W-1:0] MODE_WAVG = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FAVG = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PAVG = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUM = 3'd3;
	localparam logic [MODE_W-1:0] MODE_AND = 3'd4;

	localparam logic REG_BIN_WIDTH = 1'b0;
	localparam logic REG_AVG_MODE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;      // accept the input word into the accumulators
		logic pass;      // width one: load the sample as the result
		logic div_start; // begin both quotients
		logic div_step;  // one quotient bit
		logic load_out;  // move the finished result into the output register
	} fcba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic closes;    // the word now taken closes its bin
		logic need_div;  // the closing mode needs a division and the weight sum is nonzero
		logic div_last;  // the last quotient bit is being made
	} fcba_sts_t;
endpackage
`default_nettype wire

[design/fcba_datapath.sv]
// Datapath: accumulators, a shared restoring divider and the output register.
`default_nettype none
module fcba_datapath import fcba_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire fcba_cmd_t                 cmd,
	output fcba_sts_t                      sts,
	input  wire logic [WIDTH_W-1:0]        cfg_width,
	input  wire logic [MODE_W-1:0]         cfg_mode,
	input  wire logic signed [DATA_W-1:0]  sample_re,
	input  wire logic signed [DATA_W-1:0]  sample_im,
	input  wire logic [WT_W-1:0]           sample_weight,
	input  wire logic                      sample_flagged,
	input  wire logic                      last_in_spectrum,
	output logic signed [RES_W-1:0]        result_re,
	output logic signed [RES_W-1:0]        result_im,
	output logic                           result_flag,
	output logic                           spectrum_done
);
	localparam int QW = SUM_W;
	localparam int CNT_W = $clog2(QW);

	logic signed [SUM_W-1:0] sum_re_q, sum_im_q;
	logic [WSUM_W-1:0] wsum_q;
	logic [WIDTH_W-1:0] fill_q;
	logic all_flag_q, and_flag_q;

	logic [WIDTH_W-1:0] eff_width;
	logic [WT_W-1:0] w;
	logic signed [DATA_W+WT_W:0] prod_re, prod_im;
	logic [WIDTH_W-1:0] fill_next;
	logic close_now;

	logic signed [SUM_W-1:0] sre_next, sim_next;
	logic [WSUM_W-1:0] wsum_next;
	logic restart, accum;

	// Effective width: zero counts as one, saturate at MAX_BIN.
	always_comb begin
		eff_width = cfg_width;
		if (cfg_width == '0)
			eff_width = WIDTH_W'(1);
		if ({19'd0, cfg_width} > 32'(MAX_BIN))
			eff_width = WIDTH_W'(MAX_BIN);
	end

	assign w = (cfg_mode == MODE_WAVG) ? sample_weight : ONE_Q8;
	assign prod_re = sample_re * $signed({1'b0, w});
	assign prod_im = sample_im * $signed({1'b0, w});
	assign fill_next = fill_q + WIDTH_W'(1);
	assign close_now = (fill_next >= eff_width) || last_in_spectrum;

	// Flag-aware accumulation rule.
	always_comb begin
		restart = 1'b0;
		accum = 1'b0;
		if (cfg_mode == MODE_PAVG)
			accum = 1'b1;
		else if (cfg_mode <= MODE_SUM) begin
			if (all_flag_q && !sample_flagged)
				restart = 1'b1;
			else if (all_flag_q == sample_flagged)
				accum = 1'b1;
		end
		sre_next = sum_re_q;
		sim_next = sum_im_q;
		wsum_next = wsum_q;
		if (restart) begin
			sre_next = SUM_W'(prod_re);
			sim_next = SUM_W'(prod_im);
			wsum_next = WSUM_W'(w);
		end else if (accum) begin
			sre_next = sum_re_q + SUM_W'(prod_re);
			sim_next = sum_im_q + SUM_W'(prod_im);
			wsum_next = wsum_q + WSUM_W'(w);
		end
	end

	// Registers holding the closed bin for the divider.
	logic [SUM_W-1:0] nre_q, nim_q;
	logic [WSUM_W-1:0] rre_q, rim_q;
	logic [WSUM_W-1:0] den_q;
	logic neg_re_q, neg_im_q, flag_hold_q, last_hold_q;
	logic [MODE_W-1:0] mode_hold_q;
	logic signed [SUM_W-1:0] close_re_q, close_im_q;
	logic [CNT_W-1:0] cnt_q;

	// Accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_re_q <= '0;
			sum_im_q <= '0;
			wsum_q <= '0;
			fill_q <= '0;
			all_flag_q <= 1'b1;
			and_flag_q <= 1'b1;
		end else if (cmd.pass || (cmd.take && close_now)) begin
			sum_re_q <= '0;
			sum_im_q <= '0;
			wsum_q <= '0;
			fill_q <= '0;
			all_flag_q <= 1'b1;
			and_flag_q <= 1'b1;
		end else if (cmd.take) begin
			sum_re_q <= sre_next;
			sum_im_q <= sim_next;
			wsum_q <= wsum_next;
			fill_q <= fill_next;
			all_flag_q <= all_flag_q && sample_flagged;
			and_flag_q <= and_flag_q && sample_flagged;
		end
	end

	logic [SUM_W-1:0] abs_re, abs_im;
	assign abs_re = sre_next[SUM_W-1] ? SUM_W'(-sre_next) : sre_next;
	assign abs_im = sim_next[SUM_W-1] ? SUM_W'(-sim_next) : sim_next;

	// One bit of each quotient per step, restoring form.
	logic [WSUM_W:0] tr_re, tr_im;
	logic [WSUM_W:0] dif_re, dif_im;
	assign tr_re = {rre_q, nre_q[SUM_W-1]};
	assign tr_im = {rim_q, nim_q[SUM_W-1]};
	assign dif_re = tr_re - {1'b0, den_q};
	assign dif_im = tr_im - {1'b0, den_q};

	assign sts = '{closes: close_now,
		need_div: (cfg_mode <= MODE_PAVG) && (wsum_next != '0),
		div_last: (cnt_q == CNT_W'(QW - 1))};

	always_ff @(posedge clk) begin
		if (cmd.take && close_now) begin
			nre_q <= abs_re;
			nim_q <= abs_im;
			rre_q <= '0;
			rim_q <= '0;
			den_q <= wsum_next;
			neg_re_q <= sre_next[SUM_W-1];
			neg_im_q <= sim_next[SUM_W-1];
			flag_hold_q <= and_flag_q && sample_flagged;
			last_hold_q <= last_in_spectrum;
			mode_hold_q <= cfg_mode;
			close_re_q <= sre_next;
			close_im_q <= sim_next;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			nre_q <= {nre_q[SUM_W-2:0], !dif_re[WSUM_W]};
			nim_q <= {nim_q[SUM_W-2:0], !dif_im[WSUM_W]};
			rre_q <= dif_re[WSUM_W] ? tr_re[WSUM_W-1:0] : dif_re[WSUM_W-1:0];
			rim_q <= dif_im[WSUM_W] ? tr_im[WSUM_W-1:0] : dif_im[WSUM_W-1:0];
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Output register, loaded with the sample on a pass, or after the closing word or the last quotient bit.
	logic signed [SUM_W-1:0] q_re, q_im;
	always_comb begin
		q_re = '0;
		q_im = '0;
		if (mode_hold_q <= MODE_PAVG) begin
			if (den_q != '0) begin
				q_re = neg_re_q ? SUM_W'(-nre_q) : nre_q;
				q_im = neg_im_q ? SUM_W'(-nim_q) : nim_q;
			end
		end else if (mode_hold_q == MODE_SUM) begin
			q_re = close_re_q >>> 8;
			q_im = close_im_q >>> 8;
			if (close_re_q[SUM_W-1] && close_re_q[7:0] != '0)
				q_re = q_re + SUM_W'(1);
			if (close_im_q[SUM_W-1] && close_im_q[7:0] != '0)
				q_im = q_im + SUM_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass) begin
			result_re <= RES_W'(sample_re);
			result_im <= RES_W'(sample_im);
			result_flag <= sample_flagged;
			spectrum_done <= last_in_spectrum;
		end else if (cmd.load_out) begin
			result_re <= q_re[RES_W-1:0];
			result_im <= q_im[RES_W-1:0];
			result_flag <= flag_hold_q;
			spectrum_done <= last_hold_q;
		end
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < WIDTH_W'(MAX_BIN)) else $error("bin fill out of range");
	a_and_implies_all: assert property (@(posedge clk) disable iff (!arst_n)
		and_flag_q |-> all_flag_q) else $error("flag AND set while bin not all flagged");
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> cnt_q < CNT_W'(QW)) else $error("divider overran");
`endif
endmodule
`default_nettype wire

[design/fcba_ctrl.sv]
// Controller: handshake, configuration registers and division sequencing.
`default_nettype none
module fcba_ctrl import fcba_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [WIDTH_W-1:0] cfg_data,
	output logic [WIDTH_W-1:0]      cfg_width,
	output logic [MODE_W-1:0]       cfg_mode,
	output fcba_cmd_t               cmd,
	input  wire fcba_sts_t          sts
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0] state_q;
	logic out_free, acc, pass_now;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width <= WIDTH_W'(1);
			cfg_mode <= MODE_WAVG;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIN_WIDTH: cfg_width <= cfg_data;
				REG_AVG_MODE:  cfg_mode <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign acc = in_valid && !in_stall;
	assign pass_now = ((cfg_width == WIDTH_W'(1)) || (cfg_width == '0))
		&& (cfg_mode <= MODE_SUM);

	always_comb begin
		cmd = '0;
		cmd.pass = acc && pass_now;
		cmd.take = acc && !pass_now;
		cmd.div_start = cmd.take && sts.closes && sts.need_div;
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_LOAD) && out_free;
	end

	// Sequence: idle, optional division, then result load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			out_valid <= cmd.pass || cmd.load_out || (out_valid && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (cmd.div_start)
						state_q <= ST_DIV;
					else if (cmd.take && sts.closes)
						state_q <= ST_LOAD;
				end
				ST_DIV: if (sts.div_last) state_q <= ST_LOAD;
				ST_LOAD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !acc) else $error("word taken while busy");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid) else $error("result lost");
	a_div_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_last) |=> state_q == ST_LOAD)
		else $error("division did not finish");
`endif
endmodule
`default_nettype wire

[design/flag_aware_channel_bin_averager.sv]
// Top level of the flag-aware channel bin averager.
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | sample_re, sample_im, sample_weight, flags
//  out     | out_valid/out_stall| result_re, result_im, result_flag, spectrum_done
//  cfg     | cfg_we             | cfg_index, cfg_data
// A word that leaves its bin open needs no further state, nor does a word at
// width one outside AND mode. A closing word in averaging modes runs the shared
// divider (one quotient bit per cycle) and then the load; sum and AND modes, and
// a bin whose weight sum is zero, go straight to the load.
// Reset is asynchronous and clears the bin and the registers to width 1, mode 0.
// A held output word stalls the input side.
`default_nettype none
module flag_aware_channel_bin_averager import fcba_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [DATA_W-1:0] sample_re,
	input  wire logic signed [DATA_W-1:0] sample_im,
	input  wire logic [WT_W-1:0]          sample_weight,
	input  wire logic                     sample_flagged,
	input  wire logic                     last_in_spectrum,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [RES_W-1:0]       result_re,
	output logic signed [RES_W-1:0]       result_im,
	output logic                          result_flag,
	output logic                          spectrum_done,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_index,
	input  wire logic [WIDTH_W-1:0]       cfg_data
);
	fcba_cmd_t cmd;
	fcba_sts_t sts;
	logic [WIDTH_W-1:0] cfg_width;
	logic [MODE_W-1:0] cfg_mode;

	fcba_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.cfg_we, .cfg_index, .cfg_data, .cfg_width, .cfg_mode, .cmd, .sts
	);

	fcba_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_width, .cfg_mode,
		.sample_re, .sample_im, .sample_weight, .sample_flagged, .last_in_spectrum,
		.result_re, .result_im, .result_flag, .spectrum_done
	);
endmodule
`default_nettype wire
